// ===== hdl/iee_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package iee_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W       = SP_W + 1;
    localparam int NUM_VARS    = 52;
    localparam int VAR_W       = 6;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        CMD_NUMBER = 3'd0,
        CMD_VAR    = 3'd1,
        CMD_OPER   = 3'd2,
        CMD_OPEN   = 3'd3,
        CMD_CLOSE  = 3'd4,
        CMD_END    = 3'd5,
        CMD_BAD6   = 3'd6,
        CMD_BAD7   = 3'd7
    } cmd_t;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [2:0] PAREN_MARK = 3'd4;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_DIV0      = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
    localparam logic [1:0] ERR_MALFORMED = 2'd3;

    // classified token passed from front to back
    typedef struct packed {
        cmd_t              cmd;
        logic [DATA_W-1:0] num;
        logic [VAR_W-1:0]  vix;
        logic [1:0]        opc;
        logic [VAR_W-1:0]  dst;
    } token_t;

    typedef enum logic [3:0] {
        ST_FETCH,
        ST_DECODE,
        ST_VAR_WAIT,
        ST_OPR_READ,
        ST_OPR_CHECK,
        ST_POP_B,
        ST_POP_A,
        ST_ARITH,
        ST_DIV,
        ST_END_CHECK,
        ST_END_READ,
        ST_EMIT
    } state_t;

    function automatic logic [1:0] prec_of(input logic [2:0] c);
        logic [1:0] p;
        unique case (c)
            3'd0, 3'd1: p = 2'd1;
            3'd2, 3'd3: p = 2'd2;
            default:    p = 2'd0;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/iee_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/iee_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iee_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire iee_pkg::token_t in_token,
    input  wire logic          pop,
    output logic               q_valid,
    output iee_pkg::token_t    q_token
);

    iee_pkg::token_t                q_mem [iee_pkg::QUEUE_DEPTH];
    logic [iee_pkg::QPTR_W:0]       cnt_reg, cnt_next;
    logic [iee_pkg::QPTR_W-1:0]     wp_reg, rp_reg;
    logic                           push;

    assign in_ready = (cnt_reg != (iee_pkg::QPTR_W+1)'(iee_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign q_token  = q_mem[rp_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg + (iee_pkg::QPTR_W+1)'(push) - (iee_pkg::QPTR_W+1)'(pop && q_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= '0;
            rp_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop && q_valid)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= in_token;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/iee_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iee_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic             done,
    output logic [31:0]      q
);

    logic [31:0] rem_reg, quo_reg, den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, neg_reg;
    logic [32:0] trial;
    logic [31:0] shifted;

    // one quotient bit per cycle, restoring
    assign shifted = {rem_reg[30:0], quo_reg[31]};
    assign trial   = {rem_reg, quo_reg[31]} - {1'b0, den_reg};
    assign done    = busy_reg && (cnt_reg == 6'd0);
    assign q       = neg_reg ? 32'd0 - quo_reg : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd32;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= a[31] ? 32'd0 - a : a;
            den_reg <= b[31] ? 32'd0 - b : b;
            neg_reg <= a[31] ^ b[31];
        end
        else if (busy_reg && cnt_reg != 6'd0)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/iee_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iee_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire iee_pkg::token_t q_token,
    output logic                 pop,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output logic [31:0]          res_value,
    output logic [5:0]           res_dst,
    output logic [1:0]           res_err
);

    localparam int SW = iee_pkg::SP_W;
    localparam int CW = iee_pkg::CNT_W;

    iee_pkg::state_t state_reg, state_next;
    iee_pkg::token_t tok_reg;
    logic [CW-1:0]   opnd_cnt_reg, opr_cnt_reg;
    logic [1:0]      err_reg;
    logic [31:0]     a_reg, b_reg;
    logic [2:0]      top_reg;
    logic [51:0]     vvalid_reg;
    logic [31:0]     prod_reg;

    // result holding register
    logic            out_valid_reg;
    logic [31:0]     out_value_reg;
    logic [5:0]      out_dst_reg;
    logic [1:0]      out_err_reg;

    // stack memories
    logic            os_we, ps_we;
    logic [SW-1:0]   os_waddr, os_raddr, ps_waddr, ps_raddr;
    logic [31:0]     os_wdata, os_rdata;
    logic [2:0]      ps_wdata, ps_rdata;

    // variable table
    logic            var_we;
    logic [31:0]     var_rdata;

    logic            div_start, div_done;
    logic [31:0]     div_q;

    logic            opnd_full, opr_full;
    logic            stop;

    iee_ram #(.WIDTH(32), .DEPTH(iee_pkg::STACK_DEPTH)) u_opnd (
        .clk(clk), .we(os_we), .waddr(os_waddr), .wdata(os_wdata),
        .raddr(os_raddr), .rdata(os_rdata)
    );

    iee_ram #(.WIDTH(3), .DEPTH(iee_pkg::STACK_DEPTH)) u_opr (
        .clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
        .raddr(ps_raddr), .rdata(ps_rdata)
    );

    iee_ram #(.WIDTH(32), .DEPTH(iee_pkg::NUM_VARS)) u_vars (
        .clk(clk), .we(var_we), .waddr(tok_reg.dst), .wdata(os_rdata),
        .raddr(tok_reg.vix), .rdata(var_rdata)
    );

    iee_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .a(a_reg), .b(b_reg), .done(div_done), .q(div_q)
    );

    assign opnd_full = (opnd_cnt_reg == CW'(iee_pkg::STACK_DEPTH));
    assign opr_full  = (opr_cnt_reg == CW'(iee_pkg::STACK_DEPTH));
    assign res_valid = out_valid_reg;
    assign res_value = out_value_reg;
    assign res_dst   = out_dst_reg;
    assign res_err   = out_err_reg;
    // operator loop ends here for an operator token
    assign stop = (tok_reg.cmd == iee_pkg::CMD_OPER) &&
                  (iee_pkg::prec_of(ps_rdata) < iee_pkg::prec_of({1'b0, tok_reg.opc}));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iee_pkg::ST_FETCH:
                if (q_valid) state_next = iee_pkg::ST_DECODE;
            iee_pkg::ST_DECODE:
            begin
                if (err_reg != iee_pkg::ERR_NONE && tok_reg.cmd != iee_pkg::CMD_END)
                    state_next = iee_pkg::ST_FETCH;
                else
                begin
                    unique case (tok_reg.cmd)
                        iee_pkg::CMD_VAR:
                            state_next = (tok_reg.vix < 6'd52 && !opnd_full) ?
                                         iee_pkg::ST_VAR_WAIT : iee_pkg::ST_FETCH;
                        iee_pkg::CMD_OPER, iee_pkg::CMD_CLOSE, iee_pkg::CMD_END:
                            state_next = iee_pkg::ST_OPR_READ;
                        default:
                            state_next = iee_pkg::ST_FETCH;
                    endcase
                end
            end
            iee_pkg::ST_VAR_WAIT:
                state_next = iee_pkg::ST_FETCH;
            iee_pkg::ST_OPR_READ:
                state_next = iee_pkg::ST_OPR_CHECK;
            iee_pkg::ST_OPR_CHECK:
            begin
                priority if (err_reg != iee_pkg::ERR_NONE)
                    state_next = (tok_reg.cmd == iee_pkg::CMD_END) ?
                                 iee_pkg::ST_END_CHECK : iee_pkg::ST_FETCH;
                else if (opr_cnt_reg == '0)
                    state_next = (tok_reg.cmd == iee_pkg::CMD_END) ?
                                 iee_pkg::ST_END_CHECK : iee_pkg::ST_FETCH;
                else if (stop)
                    state_next = iee_pkg::ST_FETCH;
                else if (ps_rdata == iee_pkg::PAREN_MARK)
                    state_next = (tok_reg.cmd == iee_pkg::CMD_CLOSE) ?
                                 iee_pkg::ST_FETCH : iee_pkg::ST_OPR_READ;
                else if (opnd_cnt_reg < CW'(2))
                    state_next = (tok_reg.cmd == iee_pkg::CMD_END) ?
                                 iee_pkg::ST_END_CHECK : iee_pkg::ST_FETCH;
                else
                    state_next = iee_pkg::ST_POP_B;
            end
            iee_pkg::ST_POP_B:
                state_next = iee_pkg::ST_POP_A;
            iee_pkg::ST_POP_A:
                state_next = iee_pkg::ST_ARITH;
            iee_pkg::ST_ARITH:
                state_next = (top_reg[1:0] == iee_pkg::OP_DIV && b_reg != '0) ?
                             iee_pkg::ST_DIV : iee_pkg::ST_OPR_READ;
            iee_pkg::ST_DIV:
                if (div_done) state_next = iee_pkg::ST_OPR_READ;
            iee_pkg::ST_END_CHECK:
                state_next = iee_pkg::ST_END_READ;
            iee_pkg::ST_END_READ:
                state_next = iee_pkg::ST_EMIT;
            iee_pkg::ST_EMIT:
                if (!out_valid_reg || res_ready) state_next = iee_pkg::ST_FETCH;
            default:
                state_next = iee_pkg::ST_FETCH;
        endcase
    end

    // memory ports and handshake outputs
    always_comb
    begin
        pop       = (state_reg == iee_pkg::ST_FETCH);
        os_we     = 1'b0;
        os_waddr  = opnd_cnt_reg[SW-1:0];
        os_wdata  = tok_reg.num;
        ps_we     = 1'b0;
        ps_waddr  = opr_cnt_reg[SW-1:0];
        ps_wdata  = (tok_reg.cmd == iee_pkg::CMD_OPEN) ? iee_pkg::PAREN_MARK
                                                       : {1'b0, tok_reg.opc};
        os_raddr  = opnd_cnt_reg[SW-1:0] - SW'(1);
        ps_raddr  = opr_cnt_reg[SW-1:0] - SW'(1);
        div_start = 1'b0;
        var_we    = (state_reg == iee_pkg::ST_EMIT) && (!out_valid_reg || res_ready) &&
                    (err_reg == iee_pkg::ERR_NONE);
        unique case (state_reg)
            iee_pkg::ST_DECODE:
                if (err_reg == iee_pkg::ERR_NONE && tok_reg.cmd == iee_pkg::CMD_NUMBER
                    && !opnd_full)
                    os_we = 1'b1;
                else if (err_reg == iee_pkg::ERR_NONE && tok_reg.cmd == iee_pkg::CMD_OPEN
                         && !opr_full)
                    ps_we = 1'b1;
            iee_pkg::ST_VAR_WAIT:
            begin
                os_we    = 1'b1;
                os_wdata = vvalid_reg[tok_reg.vix] ? var_rdata : '0;
            end
            iee_pkg::ST_OPR_CHECK:
                if (err_reg == iee_pkg::ERR_NONE && tok_reg.cmd == iee_pkg::CMD_OPER
                    && (opr_cnt_reg == '0 || stop) && !opr_full)
                    ps_we = 1'b1;
            // right operand is on the read port now, fetch the left one
            iee_pkg::ST_POP_B:
                os_raddr = opnd_cnt_reg[SW-1:0] - SW'(2);
            iee_pkg::ST_ARITH:
            begin
                os_waddr = opnd_cnt_reg[SW-1:0];
                unique case (top_reg[1:0])
                    iee_pkg::OP_ADD: os_wdata = a_reg + b_reg;
                    iee_pkg::OP_SUB: os_wdata = a_reg - b_reg;
                    iee_pkg::OP_MUL: os_wdata = prod_reg;
                    default:         os_wdata = '0;
                endcase
                os_we = (top_reg[1:0] != iee_pkg::OP_DIV);
                div_start = (top_reg[1:0] == iee_pkg::OP_DIV) && (b_reg != '0);
            end
            iee_pkg::ST_DIV:
            begin
                os_wdata = div_q;
                os_we    = div_done;
            end
            iee_pkg::ST_END_CHECK:
                os_raddr = '0;
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iee_pkg::ST_FETCH;
            opnd_cnt_reg  <= '0;
            opr_cnt_reg   <= '0;
            err_reg       <= iee_pkg::ERR_NONE;
            vvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // result register loads in emit, drains on the output handshake
            if (state_reg == iee_pkg::ST_EMIT && (!out_valid_reg || res_ready))
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                iee_pkg::ST_DECODE:
                    if (err_reg == iee_pkg::ERR_NONE)
                    begin
                        unique case (tok_reg.cmd)
                            iee_pkg::CMD_NUMBER:
                                if (opnd_full) err_reg <= iee_pkg::ERR_OVERFLOW;
                                else opnd_cnt_reg <= opnd_cnt_reg + CW'(1);
                            iee_pkg::CMD_VAR:
                                if (tok_reg.vix >= 6'd52) err_reg <= iee_pkg::ERR_MALFORMED;
                                else if (opnd_full) err_reg <= iee_pkg::ERR_OVERFLOW;
                            iee_pkg::CMD_OPEN:
                                if (opr_full) err_reg <= iee_pkg::ERR_OVERFLOW;
                                else opr_cnt_reg <= opr_cnt_reg + CW'(1);
                            iee_pkg::CMD_BAD6, iee_pkg::CMD_BAD7:
                                err_reg <= iee_pkg::ERR_MALFORMED;
                            default:
                            begin
                            end
                        endcase
                    end
                iee_pkg::ST_VAR_WAIT:
                    opnd_cnt_reg <= opnd_cnt_reg + CW'(1);
                iee_pkg::ST_OPR_CHECK:
                    if (err_reg == iee_pkg::ERR_NONE)
                    begin
                        priority if (opr_cnt_reg == '0 || stop)
                        begin
                            if (tok_reg.cmd == iee_pkg::CMD_CLOSE)
                                err_reg <= iee_pkg::ERR_MALFORMED;
                            else if (tok_reg.cmd == iee_pkg::CMD_OPER)
                            begin
                                if (opr_full) err_reg <= iee_pkg::ERR_OVERFLOW;
                                else opr_cnt_reg <= opr_cnt_reg + CW'(1);
                            end
                        end
                        else
                        begin
                            opr_cnt_reg <= opr_cnt_reg - CW'(1);
                            if (ps_rdata == iee_pkg::PAREN_MARK)
                            begin
                                if (tok_reg.cmd == iee_pkg::CMD_END)
                                    err_reg <= iee_pkg::ERR_MALFORMED;
                            end
                            else if (opnd_cnt_reg < CW'(2))
                                err_reg <= iee_pkg::ERR_MALFORMED;
                        end
                    end
                iee_pkg::ST_POP_B:
                    opnd_cnt_reg <= opnd_cnt_reg - CW'(1);
                iee_pkg::ST_POP_A:
                    opnd_cnt_reg <= opnd_cnt_reg - CW'(1);
                iee_pkg::ST_ARITH:
                    if (top_reg[1:0] == iee_pkg::OP_DIV && b_reg == '0)
                        err_reg <= iee_pkg::ERR_DIV0;
                    else if (top_reg[1:0] != iee_pkg::OP_DIV)
                        opnd_cnt_reg <= opnd_cnt_reg + CW'(1);
                iee_pkg::ST_DIV:
                    if (div_done) opnd_cnt_reg <= opnd_cnt_reg + CW'(1);
                iee_pkg::ST_END_CHECK:
                    if (err_reg == iee_pkg::ERR_NONE &&
                        (opnd_cnt_reg != CW'(1) || tok_reg.dst >= 6'd52))
                        err_reg <= iee_pkg::ERR_MALFORMED;
                iee_pkg::ST_EMIT:
                    if (!out_valid_reg || res_ready)
                    begin
                        if (err_reg == iee_pkg::ERR_NONE)
                            vvalid_reg[tok_reg.dst] <= 1'b1;
                        opnd_cnt_reg <= '0;
                        opr_cnt_reg  <= '0;
                        err_reg      <= iee_pkg::ERR_NONE;
                    end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == iee_pkg::ST_FETCH && q_valid)
            tok_reg <= q_token;
        if (state_reg == iee_pkg::ST_OPR_CHECK)
            top_reg <= ps_rdata;
        // right operand first, then the deeper left one with its product
        if (state_reg == iee_pkg::ST_POP_B)
            b_reg <= os_rdata;
        if (state_reg == iee_pkg::ST_POP_A)
        begin
            a_reg    <= os_rdata;
            prod_reg <= os_rdata * b_reg;
        end
        if (state_reg == iee_pkg::ST_EMIT && (!out_valid_reg || res_ready))
        begin
            out_value_reg <= (err_reg == iee_pkg::ERR_NONE) ? os_rdata : '0;
            out_dst_reg   <= tok_reg.dst;
            out_err_reg   <= err_reg;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/infix_expression_evaluator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  | dir | tdata fields (low bit up)                         | tuser
// s_axis   | in  | number_value, variable_index, operator_code, dest | command
// m_axis   | out | result_value, result_destination                  | error_code
// a beat waits in the token queue until the back side fetches it. number
// and open paren tokens are pushed in decode, variable tokens after a table
// read; operator, close and end tokens pop two operands per reduction, a divide
// waiting on the divider (one quotient bit per cycle); end then checks and emits.
// the token queue holds 4 beats, so the front side keeps accepting while
// the back side reduces, until the queue fills; end waits only while an earlier result is unread.
// reset clears counts, stacks (by count), errors and variable valid bits.
module infix_expression_evaluator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // number_value, variable_index, operator_code, destination_index
    input  wire logic [2:0]  s_axis_tuser,  // command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // result_value, result_destination
    output logic [1:0]       m_axis_tuser   // error_code
);

    iee_pkg::token_t in_tok, q_tok;
    logic            q_valid, q_pop;
    logic [31:0]     rv;
    logic [5:0]      rd;

    // unpack input beat
    always_comb
    begin
        in_tok.cmd = iee_pkg::cmd_t'(s_axis_tuser);
        in_tok.num = s_axis_tdata[31:0];
        in_tok.vix = s_axis_tdata[37:32];
        in_tok.opc = s_axis_tdata[39:38];
        in_tok.dst = s_axis_tdata[45:40];
    end

    iee_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_token(in_tok),
        .pop(q_pop), .q_valid(q_valid), .q_token(q_tok)
    );

    iee_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_token(q_tok), .pop(q_pop),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .res_value(rv), .res_dst(rd), .res_err(m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, rd, rv};

    // a result never carries a destination beyond the table when it is ok
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == iee_pkg::ERR_NONE |-> rd < 6'd52)
        else $error("ok result with bad destination");

    // failed expressions report zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != iee_pkg::ERR_NONE |-> rv == 32'd0)
        else $error("error result not zero");

endmodule
`default_nettype wire
